// File: rtl/mfs_pkg.sv
`timescale 1ns / 1ps
package mfs_pkg;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_UNBLOCK = 3'd1,
    REQ_TICK    = 3'd2,
    REQ_BLOCK   = 3'd3,
    REQ_EXIT    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_QUANTUM1    = 2'd1;
  localparam logic [1:0] CFG_QUANTUM2    = 2'd2;
  localparam logic [1:0] CFG_QUANTUM3    = 2'd3;

  localparam int CFG_DATA_WIDTH = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UNBLK_DO,
    S_PUSH,
    S_SEL_SCAN,
    S_SEL_READ,
    S_SEL_WAIT,
    S_SEL_DONE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_clear;
    logic scan_step;
    logic scan_free;
    logic unblk_prep;
    logic push;
    logic blk_write;
    logic sel_clear;
    logic sel_step;
    logic sel_read;
    logic sel_take;
    logic sel_none;
    logic tick_dec;
    logic set_full;
    logic set_notfound;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic run_idle;
    logic expire;
    logic scan_done;
    logic scan_hit;
    logic push_ok;
    logic sel_done;
    logic sel_found;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/mfs_if.sv
`timescale 1ns / 1ps
interface mfs_req_if #(parameter int ID_WIDTH = 8);
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [ID_WIDTH-1:0] task_id;
  logic [ID_WIDTH-1:0] running_task;
  logic                running_is_idle;
  modport source (output valid, req_type, task_id, running_task, running_is_idle,
                  input ready);
  modport sink (input valid, req_type, task_id, running_task, running_is_idle,
                output ready);
endinterface

interface mfs_res_if #(parameter int ID_WIDTH = 8);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] next_task;
  logic                next_is_idle;
  logic [1:0]          status;
  modport source (output valid, next_task, next_is_idle, status, input ready);
  modport sink (input valid, next_task, next_is_idle, status, output ready);
endinterface

// File: rtl/mfs_ctrl.sv
`timescale 1ns / 1ps
module mfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfs_pkg::sts_t sts,
  output mfs_pkg::cmd_t cmd
);
  import mfs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (sts.req)
          REQ_LOAD:    state_next = S_PUSH;
          REQ_UNBLOCK: state_next = S_SCAN;
          REQ_TICK:    state_next = !sts.expire ? S_OUT
                                  : (sts.run_idle ? S_SEL_SCAN : S_PUSH);
          REQ_BLOCK:   state_next = sts.run_idle ? S_SEL_SCAN : S_SCAN;
          REQ_EXIT:    state_next = S_SEL_SCAN;
          default:     state_next = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_hit) state_next = (sts.req == REQ_UNBLOCK) ? S_UNBLK_DO : S_SEL_SCAN;
        else if (sts.scan_done)
          state_next = (sts.req == REQ_UNBLOCK) ? S_OUT : S_SEL_SCAN;
      end
      S_UNBLK_DO: state_next = S_PUSH;
      S_PUSH: state_next = (sts.req == REQ_LOAD || sts.req == REQ_UNBLOCK) ? S_OUT
                                                                          : S_SEL_SCAN;
      S_SEL_SCAN: begin
        if (sts.sel_found) state_next = S_SEL_READ;
        else if (sts.sel_done) state_next = S_OUT;
      end
      S_SEL_READ: state_next = S_SEL_WAIT;
      S_SEL_WAIT: state_next = S_SEL_DONE;
      S_SEL_DONE: state_next = S_OUT;
      S_OUT: if (!sts.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      S_DECODE: begin
        cmd.scan_clear = 1'b1;
        cmd.sel_clear = 1'b1;
        cmd.scan_free = (sts.req == REQ_BLOCK);
        if (sts.req == REQ_TICK && !sts.expire) cmd.tick_dec = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_free = (sts.req == REQ_BLOCK);
        cmd.scan_step = !sts.scan_hit && !sts.scan_done;
        if (sts.req == REQ_BLOCK) begin
          cmd.blk_write = sts.scan_hit;
          cmd.set_full = !sts.scan_hit && sts.scan_done;
        end else begin
          cmd.set_notfound = !sts.scan_hit && sts.scan_done;
        end
      end
      S_UNBLK_DO: cmd.unblk_prep = 1'b1;
      S_PUSH: begin
        cmd.push = 1'b1;
        cmd.set_full = !sts.push_ok;
      end
      S_SEL_SCAN: begin
        cmd.sel_step = !sts.sel_found && !sts.sel_done;
        cmd.sel_none = !sts.sel_found && sts.sel_done;
      end
      S_SEL_READ: cmd.sel_read = 1'b1;
      S_SEL_DONE: cmd.sel_take = 1'b1;
      S_OUT: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DECODE) else $error("no decode after transfer");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.set_full && cmd.set_notfound)) else $error("two error codes");
endmodule

// File: rtl/mfs_dp.sv
`timescale 1ns / 1ps
module mfs_dp #(
  parameter int LEVELS        = 4,
  parameter int QUEUE_DEPTH   = 16,
  parameter int BLOCKED_DEPTH = 16,
  parameter int ID_WIDTH      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  mfs_pkg::cmd_t       cmd,
  output mfs_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [2:0]          req_type,
  input  logic [ID_WIDTH-1:0] task_id,
  input  logic [ID_WIDTH-1:0] running_task,
  input  logic                running_is_idle,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [ID_WIDTH-1:0] next_task,
  output logic                next_is_idle,
  output logic [1:0]          status
);
  import mfs_pkg::*;

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;
  localparam int BCW = $clog2(BLOCKED_DEPTH + 1);
  localparam int LCW = $clog2(LEVELS + 1);
  localparam int SW = $clog2(LEVELS * QUEUE_DEPTH);

  logic [2:0] level_count;
  logic [7:0] quantum1, quantum2, quantum3;

  logic [ID_WIDTH-1:0] store [LEVELS*QUEUE_DEPTH];
  logic [QW-1:0] head [LEVELS];
  logic [CW-1:0] count [LEVELS];
  logic [BLOCKED_DEPTH-1:0] blk_valid;
  logic [ID_WIDTH-1:0] blk_id [BLOCKED_DEPTH];
  logic [LW-1:0] blk_level [BLOCKED_DEPTH];
  logic [7:0] quantum_left;
  logic [LW-1:0] current_level;

  req_t req;
  logic [ID_WIDTH-1:0] tid, run;
  logic run_idle;
  logic [BCW-1:0] scan_idx;
  logic [LCW-1:0] sel_idx;
  logic [LW-1:0] push_level, hit_level;
  logic [ID_WIDTH-1:0] push_id, rd_data;
  logic [BW-1:0] hit_idx;
  logic [1:0] stat;
  logic [ID_WIDTH-1:0] res_task;
  logic res_idle;
  logic [LCW-1:0] n_use;

  always_comb begin
    if (level_count == 3'd0) n_use = LCW'(1);
    else if (32'(level_count) > LEVELS) n_use = LCW'(LEVELS);
    else n_use = LCW'(level_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 3'd4;
      quantum1 <= 8'd2;
      quantum2 <= 8'd4;
      quantum3 <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_COUNT: level_count <= cfg_data[2:0];
        CFG_QUANTUM1:    quantum1 <= cfg_data;
        CFG_QUANTUM2:    quantum2 <= cfg_data;
        CFG_QUANTUM3:    quantum3 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [BW-1:0] sidx;
  logic [LW-1:0] slv;
  logic scan_match, push_ok;
  logic [LW-1:0] demote;
  logic [LW-1:0] last_lv;
  logic [LW-1:0] unblk_tgt;
  logic [QW:0] wr_sum;
  logic [QW-1:0] wr_slot, head_inc;
  logic [SW-1:0] wr_addr, rd_addr;
  assign sidx = scan_idx[BW-1:0];
  assign slv = sel_idx[LW-1:0];
  assign last_lv = LW'(n_use - LCW'(1));
  assign scan_match = (scan_idx < BCW'(BLOCKED_DEPTH)) &&
                      (cmd.scan_free ? !blk_valid[sidx]
                                     : (blk_valid[sidx] && blk_id[sidx] == tid));
  assign push_ok = (count[push_level] < CW'(QUEUE_DEPTH));

  assign wr_sum = {1'b0, head[push_level]} + (QW+1)'(count[push_level]);
  assign wr_slot = (wr_sum >= (QW+1)'(QUEUE_DEPTH)) ? QW'(wr_sum - (QW+1)'(QUEUE_DEPTH))
                                                   : wr_sum[QW-1:0];
  assign head_inc = (head[slv] == QW'(QUEUE_DEPTH - 1)) ? '0 : head[slv] + QW'(1);
  assign wr_addr = SW'(32'(push_level) * QUEUE_DEPTH + 32'(wr_slot));
  assign rd_addr = SW'(32'(slv) * QUEUE_DEPTH + 32'(head[slv]));

  always_comb begin
    if ({1'b0, current_level} + (LW+1)'(1) < (LW+1)'(n_use)) demote = current_level + LW'(1);
    else demote = current_level;
    if (demote > last_lv) demote = last_lv;
    unblk_tgt = (hit_level == '0) ? '0 : hit_level - LW'(1);
    if (unblk_tgt > last_lv) unblk_tgt = last_lv;
  end

  assign sts.req = req;
  assign sts.run_idle = run_idle;
  assign sts.expire = (quantum_left <= 8'd1);
  assign sts.scan_done = (scan_idx >= BCW'(BLOCKED_DEPTH));
  assign sts.scan_hit = scan_match;
  assign sts.push_ok = push_ok;
  assign sts.sel_done = (sel_idx >= n_use);
  assign sts.sel_found = (sel_idx < n_use) && (count[slv] != '0);
  assign sts.out_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) store[wr_addr] <= push_id;
    if (cmd.sel_read) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= req_t'(req_type);
      tid <= task_id;
      run <= running_task;
      run_idle <= running_is_idle;
      stat <= ST_OK;
      res_task <= '0;
      res_idle <= 1'b0;
    end
    if (cmd.scan_clear) scan_idx <= '0;
    else if (cmd.scan_step) scan_idx <= scan_idx + BCW'(1);
    if (cmd.sel_clear) sel_idx <= '0;
    else if (cmd.sel_step) sel_idx <= sel_idx + LCW'(1);
    if (cmd.scan_clear) begin
      if (req == REQ_LOAD) begin
        push_level <= '0;
        push_id <= tid;
      end else begin
        push_level <= demote;
        push_id <= run;
      end
      if (req == REQ_TICK && !(quantum_left <= 8'd1)) begin
        res_task <= run;
        res_idle <= run_idle;
      end
    end
    if (scan_match && !cmd.scan_free) begin
      hit_idx <= sidx;
      hit_level <= blk_level[sidx];
    end
    if (cmd.unblk_prep) begin
      push_level <= unblk_tgt;
      push_id <= tid;
    end
    if (cmd.blk_write) begin
      blk_id[sidx] <= run;
      blk_level[sidx] <= current_level;
    end
    if (cmd.set_full) stat <= (req == REQ_UNBLOCK) ? ST_FULL : ST_FULL;
    if (cmd.set_notfound) stat <= ST_NOTFOUND;
    if (cmd.sel_take) res_task <= rd_data;
    if (cmd.sel_none) begin
      res_task <= '0;
      res_idle <= 1'b1;
    end
    if (cmd.out_load) begin
      next_task <= res_task;
      next_is_idle <= res_idle;
      status <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        count[l] <= '0;
      end
      blk_valid <= '0;
      quantum_left <= '0;
      current_level <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.push && push_ok) begin
        count[push_level] <= count[push_level] + CW'(1);
        if (req == REQ_UNBLOCK) blk_valid[hit_idx] <= 1'b0;
      end
      if (cmd.blk_write) blk_valid[sidx] <= 1'b1;
      if (cmd.tick_dec) quantum_left <= quantum_left - 8'd1;
      if (cmd.sel_clear && req != REQ_TICK) quantum_left <= quantum_left;
      if (cmd.sel_none) quantum_left <= '0;
      if (cmd.sel_take) begin
        head[slv] <= head_inc;
        count[slv] <= count[slv] - CW'(1);
        current_level <= slv;
        case (slv)
          LW'(0):  quantum_left <= 8'd1;
          LW'(1):  quantum_left <= quantum1;
          LW'(2):  quantum_left <= quantum2;
          default: quantum_left <= quantum3;
        endcase
      end
      if (cmd.out_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.sel_take |-> count[slv] != '0) else $error("take from empty level");
  a_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && push_ok) |=> count[$past(push_level)] != '0) else $error("count lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> $stable(next_task) && $stable(status))
    else $error("result changed while stalled");
endmodule

// File: rtl/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// Throughput: one request at a time; unblock and block walk the blocked table one
// entry a cycle, selection walks the levels one a cycle and reads the queue memory.
// Reset: synchronous, active high; clears queues, blocked valid bits, quantum.
module multilevel_feedback_scheduler #(
  parameter int LEVELS        = 4,
  parameter int QUEUE_DEPTH   = 16,
  parameter int BLOCKED_DEPTH = 16,
  parameter int ID_WIDTH      = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [mfs_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  mfs_req_if.sink    req,
  mfs_res_if.source  res
);
  import mfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .sts(sts), .cmd(cmd)
  );

  mfs_dp #(
    .LEVELS(LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH),
    .BLOCKED_DEPTH(BLOCKED_DEPTH), .ID_WIDTH(ID_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(req.req_type), .task_id(req.task_id),
    .running_task(req.running_task), .running_is_idle(req.running_is_idle),
    .res_valid(res.valid), .res_ready(res.ready), .next_task(res.next_task),
    .next_is_idle(res.next_is_idle), .status(res.status)
  );
endmodule

// File: test/multilevel_feedback_scheduler_tb.sv
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_tb;
  import mfs_pkg::*;

  localparam int NLEV = 4;
  localparam int QDEPTH = 16;
  localparam int BDEPTH = 16;

  typedef struct packed {
    req_t       kind;
    logic [7:0] tid;
    logic [7:0] run;
    logic       run_idle;
  } sched_req_t;

  typedef struct packed {
    logic [7:0] next_task;
    logic       next_idle;
    logic [1:0] status;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_LEVEL_COUNT;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  mfs_req_if #(.ID_WIDTH(8)) req_ch ();
  mfs_res_if #(.ID_WIDTH(8)) res_ch ();

  multilevel_feedback_scheduler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .res(res_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler shadow state
  logic [2:0] lvl_cnt_reg;
  logic [7:0] quant_reg [1:3];
  logic [7:0] ready_mem [NLEV][QDEPTH];
  int ready_hd [NLEV];
  int ready_ct [NLEV];
  logic blk_v [BDEPTH];
  logic [7:0] blk_tid [BDEPTH];
  int blk_lvl [BDEPTH];
  int quant_left;
  int cur_lvl;

  sched_req_t pending_reqs[$];
  sched_res_t expected_res[$];
  int n_sent, n_got, n_bad;
  int hold_off;
  bit drain_stop;

  function automatic int lvls_used();
    if (lvl_cnt_reg == 0) return 1;
    if (lvl_cnt_reg > NLEV) return NLEV;
    return int'(lvl_cnt_reg);
  endfunction

  function automatic bit enqueue(int lv, logic [7:0] id);
    if (ready_ct[lv] >= QDEPTH) return 0;
    ready_mem[lv][(ready_hd[lv] + ready_ct[lv]) % QDEPTH] = id;
    ready_ct[lv]++;
    return 1;
  endfunction

  function automatic void pick_next(ref sched_res_t r);
    int n;
    n = lvls_used();
    quant_left = 0;
    for (int lv = 0; lv < n; lv++) begin
      if (ready_ct[lv] != 0) begin
        r.next_task = ready_mem[lv][ready_hd[lv]];
        r.next_idle = 1'b0;
        ready_hd[lv] = (ready_hd[lv] + 1) % QDEPTH;
        ready_ct[lv]--;
        quant_left = (lv == 0) ? 1 : quant_reg[lv];
        cur_lvl = lv;
        return;
      end
    end
    r.next_task = '0;
    r.next_idle = 1'b1;
  endfunction

  function automatic sched_res_t schedule(sched_req_t q);
    sched_res_t r;
    int n, i, tgt;
    r = '0;
    n = lvls_used();
    case (q.kind)
      REQ_LOAD: if (!enqueue(0, q.tid)) r.status = ST_FULL;
      REQ_UNBLOCK: begin
        for (i = 0; i < BDEPTH; i++) if (blk_v[i] && blk_tid[i] == q.tid) break;
        if (i == BDEPTH) r.status = ST_NOTFOUND;
        else begin
          tgt = blk_lvl[i] == 0 ? 0 : blk_lvl[i] - 1;
          if (tgt > n - 1) tgt = n - 1;
          if (enqueue(tgt, q.tid)) blk_v[i] = 1'b0;
          else r.status = ST_FULL;
        end
      end
      REQ_TICK: begin
        if (quant_left <= 1) begin
          if (!q.run_idle) begin
            tgt = cur_lvl + 1 < n ? cur_lvl + 1 : cur_lvl;
            if (tgt > n - 1) tgt = n - 1;
            if (!enqueue(tgt, q.run)) r.status = ST_FULL;
          end
          pick_next(r);
        end else begin
          quant_left--;
          r.next_task = q.run;
          r.next_idle = q.run_idle;
        end
      end
      REQ_BLOCK: begin
        if (!q.run_idle) begin
          for (i = 0; i < BDEPTH; i++) if (!blk_v[i]) break;
          if (i == BDEPTH) r.status = ST_FULL;
          else begin
            blk_v[i] = 1'b1;
            blk_tid[i] = q.run;
            blk_lvl[i] = cur_lvl;
          end
        end
        pick_next(r);
      end
      REQ_EXIT: pick_next(r);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int tx_gap;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) n_sent++;
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        sched_req_t q;
        q = pending_reqs.pop_front();
        expected_res = {expected_res, schedule(q)};
        req_ch.valid <= 1'b1;
        req_ch.req_type <= q.kind;
        req_ch.task_id <= q.tid;
        req_ch.running_task <= q.run;
        req_ch.running_is_idle <= q.run_idle;
        tx_gap <= gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  int rx_gap;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        sched_res_t e;
        n_got++;
        if (expected_res.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result task=%0d idle=%0b st=%0d",
                                    res_ch.next_task, res_ch.next_is_idle, res_ch.status);
        end else begin
          e = expected_res.pop_front();
          if (e.next_task !== res_ch.next_task || e.next_idle !== res_ch.next_is_idle ||
              e.status !== res_ch.status) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp task=%0d idle=%0b st=%0d got task=%0d idle=%0b st=%0d",
                       e.next_task, e.next_idle, e.status, res_ch.next_task,
                       res_ch.next_is_idle, res_ch.status);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (res_ch.valid && res_ch.ready) rx_gap <= gap_len();
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.task_id = '0;
    req_ch.running_task = '0;
    req_ch.running_is_idle = 1'b0;
    res_ch.ready = 1'b0;
  end

  task automatic add_req(req_t k, int tid, int run, bit ridle);
    sched_req_t q;
    q.kind = k;
    q.tid = tid[7:0];
    q.run = run[7:0];
    q.run_idle = ridle;
    pending_reqs = {pending_reqs, q};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEVEL_COUNT: lvl_cnt_reg = val[2:0];
      CFG_QUANTUM1:    quant_reg[1] = val[7:0];
      CFG_QUANTUM2:    quant_reg[2] = val[7:0];
      default:         quant_reg[3] = val[7:0];
    endcase
  endtask

  // mostly well-formed traffic on a small id pool so unblocks find blocked tasks
  task automatic random_phase(int count);
    logic [7:0] on_cpu;
    bit on_idle;
    int p;
    on_cpu = 8'd0;
    on_idle = 1'b1;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 3) on_cpu = 8'($urandom_range(0, 255));
      if (p < 22)
        add_req(REQ_LOAD, $urandom_range(0, 99) < 80 ? $urandom_range(0, 31)
                : $urandom_range(0, 255), on_cpu, on_idle);
      else if (p < 40)
        add_req(REQ_UNBLOCK, $urandom_range(0, 99) < 85 ? $urandom_range(0, 31)
                : $urandom_range(0, 255), on_cpu, on_idle);
      else if (p < 72)
        add_req(REQ_TICK, $urandom_range(0, 255), on_cpu,
                $urandom_range(0, 19) == 0 ? ~on_idle : on_idle);
      else if (p < 87)
        add_req(REQ_BLOCK, $urandom_range(0, 255), on_cpu, on_idle);
      else if (p < 97)
        add_req(REQ_EXIT, $urandom_range(0, 255), on_cpu, on_idle);
      else
        add_req(req_t'($urandom_range(5, 7)), $urandom_range(0, 255), on_cpu, on_idle);
      if (p >= 3 && $urandom_range(0, 3) == 0) on_cpu = 8'($urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) on_idle = ~on_idle;
    end
  endtask

  initial begin
    lvl_cnt_reg = 3'd4;
    quant_reg[1] = 8'd2;
    quant_reg[2] = 8'd4;
    quant_reg[3] = 8'd8;
    for (int l = 0; l < NLEV; l++) begin
      ready_hd[l] = 0;
      ready_ct[l] = 0;
      for (int s = 0; s < QDEPTH; s++) ready_mem[l][s] = '0;
    end
    for (int b = 0; b < BDEPTH; b++) begin
      blk_v[b] = 1'b0;
      blk_tid[b] = '0;
      blk_lvl[b] = 0;
    end
    quant_left = 0;
    cur_lvl = 0;
    n_sent = 0;
    n_got = 0;
    n_bad = 0;
    hold_off = 0;
    drain_stop = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty selection, field extremes, fills, unknown types
    add_req(REQ_EXIT, 0, 0, 1);
    add_req(REQ_TICK, 0, 255, 1);
    add_req(REQ_UNBLOCK, 255, 0, 0);
    add_req(REQ_LOAD, 0, 0, 0);
    add_req(REQ_LOAD, 255, 0, 0);
    add_req(REQ_TICK, 0, 200, 0);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_BLOCK, 0, 255, 0);
    add_req(REQ_BLOCK, 0, 7, 1);
    add_req(REQ_UNBLOCK, 255, 0, 0);
    add_req(REQ_UNBLOCK, 255, 0, 0);
    add_req(req_t'(3'd5), 255, 255, 1);
    add_req(req_t'(3'd7), 170, 85, 0);
    for (int k = 0; k < 18; k++) add_req(REQ_BLOCK, 0, k, 0);
    drain();

    // full level 0 and full blocked table
    for (int k = 0; k < 18; k++) add_req(REQ_LOAD, k, 0, 0);
    for (int k = 0; k < 10; k++) add_req(REQ_UNBLOCK, k, 0, 0);
    drain();

    write_reg(CFG_LEVEL_COUNT, 1);
    write_reg(CFG_QUANTUM1, 255);
    write_reg(CFG_QUANTUM2, 1);
    write_reg(CFG_QUANTUM3, 3);
    random_phase(250);
    drain();

    write_reg(CFG_LEVEL_COUNT, 0);
    random_phase(150);
    drain();

    write_reg(CFG_LEVEL_COUNT, 7);
    write_reg(CFG_QUANTUM1, 1);
    write_reg(CFG_QUANTUM2, 255);
    write_reg(CFG_QUANTUM3, 1);
    random_phase(350);
    // stall the receiver long enough to back up the input side
    hold_off = 300;
    random_phase(50);
    drain();

    write_reg(CFG_LEVEL_COUNT, 2);
    write_reg(CFG_QUANTUM1, 3);
    random_phase(350);
    drain();

    write_reg(CFG_LEVEL_COUNT, 3);
    write_reg(CFG_QUANTUM2, 2);
    random_phase(300);
    drain();

    write_reg(CFG_LEVEL_COUNT, 4);
    write_reg(CFG_QUANTUM1, 2);
    write_reg(CFG_QUANTUM2, 4);
    write_reg(CFG_QUANTUM3, 255);
    random_phase(350);
    drain();

    $display("covered %0d requests over six register settings, incl. full queues,",
             n_sent);
    $display("full blocked table, unknown unblocks, idle runs and a long output stall");
    if (n_bad == 0 && expected_res.size() == 0)
      $display("multilevel_feedback_scheduler_tb: done, clean");
    else
      $display("multilevel_feedback_scheduler_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout: %0d results outstanding", expected_res.size());
    $display("multilevel_feedback_scheduler_tb: done, errors");
    $finish;
  end

endmodule
